[rtl/rsi_pkg.sv]
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared widths, limits and state codes for the relative strength index core.
// ----------------------------------------------------------------------------
`default_nettype none

package rsi_pkg;

    localparam int MAX_WINDOW = 256;
    localparam int PTR_W      = $clog2(MAX_WINDOW);
    localparam int SEEN_W     = $clog2(MAX_WINDOW + 1);
    localparam int PRICE_W    = 32;
    localparam int CHG_W      = PRICE_W + 1;
    localparam int SUM_W      = CHG_W + PTR_W;
    localparam int RSI_W      = 15;
    localparam int PROD_W     = SUM_W + RSI_W;
    localparam int WIN_W      = 9;

    localparam logic [RSI_W-1:0]  RSI_SCALE   = RSI_W'(25600);
    localparam logic [WIN_W-1:0]  WIN_RESET   = WIN_W'(14);
    localparam logic [SEEN_W-1:0] WIN_MAX     = SEEN_W'(MAX_WINDOW);
    localparam logic [PTR_W-1:0]  PTR_LAST    = PTR_W'(MAX_WINDOW - 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SWEEP = 5'b00010,
        S_MUL   = 5'b00100,
        S_DIV   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

endpackage

`default_nettype wire

[rtl/relative_strength_index_core.sv]
// ----------------------------------------------------------------------------
// relative_strength_index_core
// Sliding-window RSI over price changes, one result per price sample.
// ----------------------------------------------------------------------------
// Each accepted sample that does not start a series writes its change from
// the previous sample into a 256-entry ring RAM. A series-start sample, or
// one that leaves fewer changes than the window length, goes from idle to
// the done state and on into the output register once that register is free.
// Otherwise the core reads the last W changes back from the ring one per
// cycle, then runs a multiply step and a 15-step restoring divider before
// the done state. The core takes the next sample only once it is back in
// idle; the single read port of the ring and the bit-serial divider set the
// pace of this path. The output register lets the next sample be taken while
// a result still waits. The ring needs no clearing.
`default_nettype none

module relative_strength_index_core
    import rsi_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [WIN_W-1:0]   i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [PRICE_W-1:0] i_price,
    input  wire logic               i_series_start,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic      [RSI_W-1:0]   o_rsi_value,
    output logic                    o_window_full
);

    t_state r_state, n_state;

    logic [WIN_W-1:0]   r_window;
    logic [PRICE_W-1:0] r_last;
    logic [PTR_W-1:0]   r_ptr;
    logic [SEEN_W-1:0]  r_seen;
    logic [PTR_W-1:0]   r_rd_addr;
    logic [SEEN_W-1:0]  r_rd_left;
    logic               r_rd_pend;
    logic [SUM_W-1:0]   r_gain;
    logic [SUM_W-1:0]   r_loss;
    logic [SUM_W-1:0]   r_den;
    logic [SUM_W-1:0]   r_rem;
    logic [RSI_W-1:0]   r_quot;
    logic [4:0]         r_cnt;
    logic               r_zero;
    logic               r_full;
    logic [RSI_W-1:0]   r_out_rsi;
    logic               r_out_full;
    logic               r_out_valid;

    logic [SEEN_W-1:0]  w_eff;
    logic               in_xfer;
    logic               out_free;
    logic [CHG_W-1:0]   change;
    logic [PTR_W-1:0]   ptr_next;
    logic [SEEN_W-1:0]  seen_next;
    logic               rd_en;
    logic [CHG_W-1:0]   rd_data;
    logic [CHG_W-1:0]   rd_mag;
    logic [PROD_W-1:0]  prod;
    logic [SUM_W:0]     trial;
    logic               qbit;

    always_comb begin
        if (r_window == '0) begin
            w_eff = SEEN_W'(1);
        end else if (SEEN_W'(r_window) > WIN_MAX) begin
            w_eff = WIN_MAX;
        end else begin
            w_eff = SEEN_W'(r_window);
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    assign change    = {1'b0, i_price} - {1'b0, r_last};
    assign ptr_next  = (r_ptr == PTR_LAST) ? '0 : r_ptr + PTR_W'(1);
    assign seen_next = (r_seen == WIN_MAX) ? r_seen : r_seen + SEEN_W'(1);

    assign rd_en  = (r_state == S_SWEEP) && (r_rd_left != '0);
    assign rd_mag = ~rd_data + CHG_W'(1);
    assign prod   = PROD_W'(r_gain) * PROD_W'(RSI_SCALE);
    assign trial  = {r_rem, r_quot[RSI_W-1]};
    assign qbit   = (trial >= {1'b0, r_den});

    rsi_ram #(
        .WIDTH (CHG_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (in_xfer && !i_series_start),
        .i_waddr (r_ptr),
        .i_wdata (change),
        .i_re    (rd_en),
        .i_raddr (r_rd_addr),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (!i_series_start && seen_next >= w_eff) begin
                        n_state = S_SWEEP;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SWEEP: begin
                if (r_rd_left == '0 && !r_rd_pend) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_cnt == 5'd1) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_window    <= WIN_RESET;
            r_last      <= '0;
            r_ptr       <= '0;
            r_seen      <= '0;
            r_rd_left   <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= rd_en;
            if (i_cfg_we) begin
                r_window <= i_cfg_data;
            end
            if (in_xfer) begin
                r_last <= i_price;
                if (i_series_start) begin
                    r_ptr  <= '0;
                    r_seen <= '0;
                end else begin
                    r_ptr     <= ptr_next;
                    r_seen    <= seen_next;
                    r_rd_left <= w_eff;
                end
            end else if (rd_en) begin
                r_rd_left <= r_rd_left - SEEN_W'(1);
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_rd_addr <= r_ptr;
            r_gain    <= '0;
            r_loss    <= '0;
            r_zero    <= 1'b1;
            r_quot    <= '0;
            r_full    <= !i_series_start && (seen_next >= w_eff);
        end else if (rd_en) begin
            r_rd_addr <= (r_rd_addr == '0) ? PTR_LAST : r_rd_addr - PTR_W'(1);
        end
        if (r_rd_pend) begin
            if (!rd_data[CHG_W-1] && rd_data != '0) begin
                r_gain <= r_gain + SUM_W'(rd_data);
            end else begin
                r_loss <= r_loss + SUM_W'(rd_mag);
            end
        end
        if (r_state == S_MUL) begin
            r_rem  <= SUM_W'(prod[PROD_W-1:RSI_W]);
            r_quot <= prod[RSI_W-1:0];
            r_den  <= r_gain + r_loss;
            r_zero <= (r_loss == '0);
            r_cnt  <= 5'(RSI_W);
        end
        if (r_state == S_DIV) begin
            r_rem  <= qbit ? SUM_W'(trial - {1'b0, r_den}) : SUM_W'(trial);
            r_quot <= {r_quot[RSI_W-2:0], qbit};
            r_cnt  <= r_cnt - 5'd1;
        end
        if (r_state == S_DONE && out_free) begin
            r_out_rsi  <= r_zero ? '0 : r_quot;
            r_out_full <= r_full;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_rsi_value   = r_out_rsi;
    assign o_window_full = r_out_full;

endmodule

`default_nettype wire

[rtl/rsi_ram.sv]
// ----------------------------------------------------------------------------
// rsi_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/rsi_chk.sv]
// ----------------------------------------------------------------------------
// rsi_chk
// Port-level checks for the relative strength index core.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_chk
    import rsi_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             o_in_ready,
    input wire logic             o_out_valid,
    input wire logic             i_out_ready,
    input wire logic [RSI_W-1:0] o_rsi_value,
    input wire logic             o_window_full
);

    a_rsi_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_rsi_value <= RSI_SCALE))
        else $error("rsi value above full scale");

    a_not_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_window_full) |-> (o_rsi_value == '0))
        else $error("nonzero rsi without a full window");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second transfer taken while an item is at work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_rsi_value) && $stable(o_window_full)))
        else $error("stalled result changed");

endmodule

bind relative_strength_index_core rsi_chk u_rsi_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_rsi_value   (o_rsi_value),
    .o_window_full (o_window_full)
);

`default_nettype wire
